/* hdl/lrs_pkg.sv */
// shared types and constants of the regression engine
package lrs_pkg;

  localparam int MAX_INPUTS  = 16;
  localparam int MAX_OUTPUTS = 4;
  localparam int IN_W        = $clog2(MAX_INPUTS);
  localparam int OUT_W       = $clog2(MAX_OUTPUTS);
  localparam int WADDR_W     = IN_W + OUT_W;
  localparam int CNT_W       = (IN_W > OUT_W) ? IN_W : OUT_W;
  localparam int VAL_W       = 24;
  localparam int RATE_W      = 16;
  localparam int ACC_W       = 40;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int IN_CNT_W    = 5;
  localparam int OUT_CNT_W   = 3;
  localparam int S_DATA_W    = 48;
  localparam int M_DATA_W    = 32;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT = 2'd1;

  typedef enum logic [1:0] {
    OP_LOAD_W = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_TARGET = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_LOADW,
    DP_LOADB,
    DP_FEAT,
    DP_RD,
    DP_MUL_SAMPLE,
    DP_ACC,
    DP_ERR,
    DP_MUL_BIAS,
    DP_BIAS_UPD,
    DP_MUL_EX,
    DP_MUL_PR,
    DP_W_UPD
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_S_RD,
    ST_S_MUL,
    ST_S_ACC,
    ST_S_EMIT,
    ST_T_EMIT,
    ST_T_BMUL,
    ST_T_BUPD,
    ST_T_RD,
    ST_T_MX,
    ST_T_MR,
    ST_T_WUPD
  } state_e;

  typedef struct packed {
    dp_op_e           op;
    logic [CNT_W-1:0] cnt;
    logic             out_load;
    logic             out_kind;
    logic             out_last;
  } dp_cmd_t;

  typedef struct packed {
    op_e              op;
    logic             samp_skip;
    logic             samp_last;
    logic             tgt_skip;
    logic [IN_W-1:0]  ni_last;
    logic [OUT_W-1:0] no_last;
    logic             slot_free;
  } dp_stat_t;

endpackage

/* hdl/lrs_ram.sv */
// generic single-port-write ram with registered read
module lrs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* hdl/lrs_ctrl.sv */
// sequencer for loads, sample accumulation, result emission and training
module lrs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  lrs_pkg::dp_stat_t stat_i,
  output lrs_pkg::dp_cmd_t  cmd_o
);
  import lrs_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        cnt_d = '0;
        case (stat_i.op)
          OP_SAMPLE: state_d = stat_i.samp_skip ? ST_IDLE : ST_S_RD;
          OP_TARGET: state_d = stat_i.tgt_skip ? ST_IDLE : ST_T_EMIT;
          default:   state_d = ST_IDLE;
        endcase
      end
      ST_S_RD:  state_d = ST_S_MUL;
      ST_S_MUL: state_d = ST_S_ACC;
      ST_S_ACC: begin
        if (cnt_q == CNT_W'(MAX_OUTPUTS - 1)) begin
          cnt_d   = '0;
          state_d = stat_i.samp_last ? ST_S_EMIT : ST_IDLE;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_S_RD;
        end
      end
      ST_S_EMIT: begin
        if (stat_i.slot_free) begin
          if (cnt_q[OUT_W-1:0] == stat_i.no_last) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      ST_T_EMIT: begin
        if (stat_i.slot_free) state_d = ST_T_BMUL;
      end
      ST_T_BMUL: state_d = ST_T_BUPD;
      ST_T_BUPD: begin
        cnt_d   = '0;
        state_d = ST_T_RD;
      end
      ST_T_RD: state_d = ST_T_MX;
      ST_T_MX: state_d = ST_T_MR;
      ST_T_MR: state_d = ST_T_WUPD;
      ST_T_WUPD: begin
        if (cnt_q[IN_W-1:0] == stat_i.ni_last) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_T_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_ready_o     = 1'b0;
    cmd_o.op       = DP_NOP;
    cmd_o.cnt      = cnt_q;
    cmd_o.out_load = 1'b0;
    cmd_o.out_kind = 1'b0;
    cmd_o.out_last = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) cmd_o.op = DP_LATCH;
      end
      ST_DISPATCH: begin
        case (stat_i.op)
          OP_LOAD_W: cmd_o.op = DP_LOADW;
          OP_LOAD_B: cmd_o.op = DP_LOADB;
          OP_SAMPLE: cmd_o.op = stat_i.samp_skip ? DP_NOP : DP_FEAT;
          OP_TARGET: cmd_o.op = stat_i.tgt_skip ? DP_NOP : DP_ERR;
          default:   cmd_o.op = DP_NOP;
        endcase
      end
      ST_S_RD:   cmd_o.op = DP_RD;
      ST_S_MUL:  cmd_o.op = DP_MUL_SAMPLE;
      ST_S_ACC:  cmd_o.op = DP_ACC;
      ST_S_EMIT: begin
        cmd_o.out_load = stat_i.slot_free;
        cmd_o.out_last = (cnt_q[OUT_W-1:0] == stat_i.no_last);
      end
      ST_T_EMIT: begin
        cmd_o.out_load = stat_i.slot_free;
        cmd_o.out_kind = 1'b1;
        cmd_o.out_last = 1'b1;
      end
      ST_T_BMUL: cmd_o.op = DP_MUL_BIAS;
      ST_T_BUPD: cmd_o.op = DP_BIAS_UPD;
      ST_T_RD:   cmd_o.op = DP_RD;
      ST_T_MX:   cmd_o.op = DP_MUL_EX;
      ST_T_MR:   cmd_o.op = DP_MUL_PR;
      ST_T_WUPD: cmd_o.op = DP_W_UPD;
      default:   cmd_o.op = DP_NOP;
    endcase
  end
endmodule

/* hdl/lrs_dp.sv */
// datapath: stores, shared multiplier, accumulators and result register
module lrs_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [lrs_pkg::S_DATA_W-1:0]      s_tdata,
  input  logic [1:0]                        s_tuser,
  input  logic                              cfg_we_i,
  input  logic [lrs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lrs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  lrs_pkg::dp_cmd_t                  cmd_i,
  output lrs_pkg::dp_stat_t                 stat_o,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [lrs_pkg::M_DATA_W-1:0]      m_tdata,
  output logic                              m_tuser,
  output logic                              m_tlast
);
  import lrs_pkg::*;

  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int RND_W   = PROD_W - 15;

  function automatic logic signed [RND_W-1:0] rnd16(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W:0] t;
    t = {v[PROD_W-1], v} + (PROD_W+1)'(32768);
    return t[PROD_W:16];
  endfunction

  function automatic logic [VAL_W-1:0] sat24(input logic signed [RND_W:0] v);
    logic [VAL_W-1:0] r;
    if (v > (RND_W+1)'(signed'(24'sh7fffff))) r = 24'h7fffff;
    else if (v < (RND_W+1)'(signed'(-24'sh800000))) r = 24'h800000;
    else r = v[VAL_W-1:0];
    return r;
  endfunction

  function automatic logic [ACC_W-1:0] sat40(input logic signed [RND_W:0] v);
    logic signed [RND_W:0] hi;
    logic signed [RND_W:0] lo;
    logic [ACC_W-1:0]      r;
    hi = (RND_W+1)'({1'b0, {(ACC_W-1){1'b1}}});
    lo = ~hi;
    if (v > hi) r = {1'b0, {(ACC_W-1){1'b1}}};
    else if (v < lo) r = {1'b1, {(ACC_W-1){1'b0}}};
    else r = v[ACC_W-1:0];
    return r;
  endfunction

  // latched item
  op_e              op_q;
  logic [IN_W-1:0]  ii_q;
  logic [OUT_W-1:0] oi_q;
  logic [VAL_W-1:0] val_q;
  logic [RATE_W-1:0] rate_q;

  logic [IN_CNT_W-1:0]  cfg_in_q;
  logic [OUT_CNT_W-1:0] cfg_out_q;
  logic [IN_CNT_W-1:0]  ni;
  logic [OUT_CNT_W-1:0] no;

  logic [VAL_W-1:0] bias_q [MAX_OUTPUTS];
  logic [ACC_W-1:0] acc_q  [MAX_OUTPUTS];
  logic [VAL_W-1:0] feat_q [MAX_INPUTS];
  logic [VAL_W-1:0] err_q;
  logic signed [PROD_W-1:0] prod_q;

  logic [MAX_INPUTS*MAX_OUTPUTS-1:0] wv_q;
  logic                              rvalid_q;

  logic                 out_valid_q;
  logic [OUT_W-1:0]     out_idx_q;
  logic [VAL_W-1:0]     out_val_q;
  logic                 out_kind_q;
  logic                 out_last_q;

  logic [OUT_W-1:0]     k;
  logic [IN_W-1:0]      fi;
  logic [WADDR_W-1:0]   raddr;
  logic                 we;
  logic [WADDR_W-1:0]   waddr;
  logic [VAL_W-1:0]     wdata;
  logic [VAL_W-1:0]     rdata;
  logic [VAL_W-1:0]     w_rd;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [RND_W-1:0]   prod_rnd;
  logic signed [RND_W:0]     acc_base;
  logic signed [RND_W:0]     err_diff;
  logic [VAL_W-1:0]          y_sat;
  logic [VAL_W-1:0]          w_new;
  logic [VAL_W-1:0]          b_new;
  logic [ACC_W-1:0]          acc_new;
  logic                      slot_free;

  assign k  = cmd_i.cnt[OUT_W-1:0];
  assign fi = cmd_i.cnt[IN_W-1:0];

  assign ni = (cfg_in_q == '0) ? IN_CNT_W'(1) :
              (cfg_in_q > IN_CNT_W'(MAX_INPUTS)) ? IN_CNT_W'(MAX_INPUTS) : cfg_in_q;
  assign no = (cfg_out_q == '0) ? OUT_CNT_W'(1) :
              (cfg_out_q > OUT_CNT_W'(MAX_OUTPUTS)) ? OUT_CNT_W'(MAX_OUTPUTS) : cfg_out_q;

  assign slot_free = !out_valid_q || m_tready;

  always_comb begin
    stat_o.op        = op_q;
    stat_o.samp_skip = ({1'b0, ii_q} >= ni);
    stat_o.samp_last = ({1'b0, ii_q} == ni - 1'b1);
    stat_o.tgt_skip  = (OUT_CNT_W'(oi_q) >= no);
    stat_o.ni_last   = IN_W'(ni - 1'b1);
    stat_o.no_last   = OUT_W'(no - 1'b1);
    stat_o.slot_free = slot_free;
  end

  // weight ram: sample walks outputs of one feature, training walks features of one output
  assign raddr = (op_q == OP_SAMPLE) ? {ii_q, k} : {fi, oi_q};
  assign w_rd  = rvalid_q ? rdata : '0;

  always_comb begin
    we    = 1'b0;
    waddr = {fi, oi_q};
    wdata = w_new;
    case (cmd_i.op)
      DP_LOADW: begin
        we    = 1'b1;
        waddr = {ii_q, oi_q};
        wdata = val_q;
      end
      DP_W_UPD: we = 1'b1;
      default:  we = 1'b0;
    endcase
  end

  lrs_ram #(
    .WIDTH(VAL_W),
    .DEPTH(MAX_INPUTS * MAX_OUTPUTS)
  ) u_wram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.op == DP_RD),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // shared multiplier operands
  always_comb begin
    mul_a = MUL_A_W'(signed'(err_q));
    mul_b = MUL_B_W'(signed'(val_q));
    case (cmd_i.op)
      DP_MUL_SAMPLE: begin
        mul_a = MUL_A_W'(signed'(w_rd));
        mul_b = MUL_B_W'(signed'(val_q));
      end
      DP_MUL_BIAS: begin
        mul_a = MUL_A_W'(signed'(err_q));
        mul_b = signed'(MUL_B_W'(rate_q));
      end
      DP_MUL_EX: begin
        mul_a = MUL_A_W'(signed'(err_q));
        mul_b = MUL_B_W'(signed'(feat_q[fi]));
      end
      DP_MUL_PR: begin
        mul_a = prod_rnd[MUL_A_W-1:0];
        mul_b = signed'(MUL_B_W'(rate_q));
      end
      default: begin
        mul_a = MUL_A_W'(signed'(err_q));
        mul_b = MUL_B_W'(signed'(val_q));
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_rnd = rnd16(prod_q);

  assign acc_base = (ii_q == '0) ? (RND_W+1)'(signed'(bias_q[k]))
                                 : (RND_W+1)'(signed'(acc_q[k]));
  assign acc_new  = sat40(acc_base + (RND_W+1)'(prod_rnd));
  assign y_sat    = sat24((RND_W+1)'(signed'(acc_q[oi_q])));
  assign err_diff = (RND_W+1)'(signed'(val_q)) - (RND_W+1)'(signed'(y_sat));
  assign b_new    = sat24((RND_W+1)'(signed'(bias_q[oi_q])) + (RND_W+1)'(prod_rnd));
  assign w_new    = sat24((RND_W+1)'(signed'(w_rd)) + (RND_W+1)'(prod_rnd));

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LATCH: begin
        op_q   <= op_e'(s_tuser);
        ii_q   <= s_tdata[IN_W-1:0];
        oi_q   <= s_tdata[IN_W+OUT_W-1:IN_W];
        val_q  <= s_tdata[IN_W+OUT_W+VAL_W-1:IN_W+OUT_W];
        rate_q <= s_tdata[IN_W+OUT_W+VAL_W+RATE_W-1:IN_W+OUT_W+VAL_W];
      end
      DP_FEAT: feat_q[ii_q] <= val_q;
      DP_ERR:  err_q <= sat24(err_diff);
      DP_MUL_SAMPLE, DP_MUL_BIAS, DP_MUL_EX, DP_MUL_PR: prod_q <= mul_p;
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_idx_q  <= cmd_i.out_kind ? oi_q : k;
      out_val_q  <= cmd_i.out_kind ? err_q : sat24((RND_W+1)'(signed'(acc_q[k])));
      out_kind_q <= cmd_i.out_kind;
      out_last_q <= cmd_i.out_last;
    end
  end

  // state that the model resets
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_in_q    <= IN_CNT_W'(MAX_INPUTS);
      cfg_out_q   <= OUT_CNT_W'(MAX_OUTPUTS);
      wv_q        <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < MAX_OUTPUTS; j++) begin
        bias_q[j] <= '0;
        acc_q[j]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_INPUT_COUNT)  cfg_in_q  <= cfg_data_i[IN_CNT_W-1:0];
        if (cfg_index_i == REG_OUTPUT_COUNT) cfg_out_q <= cfg_data_i[OUT_CNT_W-1:0];
      end
      if (we) wv_q[waddr] <= 1'b1;
      if (cmd_i.op == DP_RD) rvalid_q <= wv_q[raddr];
      case (cmd_i.op)
        DP_LOADB:    bias_q[oi_q] <= val_q;
        DP_BIAS_UPD: bias_q[oi_q] <= b_new;
        DP_ACC:      acc_q[k]     <= acc_new;
        default: ;
      endcase
      if (cmd_i.out_load)  out_valid_q <= 1'b1;
      else if (m_tready)   out_valid_q <= 1'b0;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {(M_DATA_W-OUT_W-VAL_W)'(0), out_val_q, out_idx_q};
  assign m_tuser  = out_kind_q;
  assign m_tlast  = out_last_q;
endmodule

/* hdl/linear_regression_sgd_engine.sv */
// top level of the regression engine: sequencer plus datapath
//  channel | direction | handshake              | payload
//  s_*     | in        | s_tvalid / s_tready    | tdata, tuser (opcode)
//  m_*     | out       | m_tvalid / m_tready    | tdata, tuser (kind), tlast
//  cfg_*   | in        | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
// load items and ignored items pass through the idle and dispatch states only
// a sample element stores its feature, then reads, multiplies and accumulates
//   per output slot, plus a prediction per output in use if last; a target
//   updates bias and weights, using the shared multiplier twice per weight
// reset is asynchronous, active low; weight contents are masked by per-entry valid bits
// a stalled result holds the emit step; input is taken only when the sequencer is idle
module linear_regression_sgd_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // in_index[3:0], out_index[5:4], value[29:6], rate[45:30], zero pad
  input  logic [lrs_pkg::S_DATA_W-1:0]        s_tdata,
  // opcode[1:0]
  input  logic [1:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // res_index[1:0], res_value[25:2], zero pad
  output logic [lrs_pkg::M_DATA_W-1:0]        m_tdata,
  // res_kind[0]
  output logic                                m_tuser,
  output logic                                m_tlast,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lrs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lrs_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import lrs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  lrs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_tvalid),
    .s_ready_o(s_tready),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  lrs_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .cfg_we_i   (cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );
endmodule

/* hdl/lrs_checker.sv */
// port-level checks for the regression engine
module lrs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [lrs_pkg::M_DATA_W-1:0]   m_tdata,
  input logic                           m_tuser,
  input logic                           m_tlast
);
  import lrs_pkg::*;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed while stalled");

  // a training error is always the only result of its item
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser |-> m_tlast) else $error("error item without last");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> m_tdata[M_DATA_W-1:OUT_W+VAL_W] == '0) else $error("pad bits set");

  // an accepted item moves the sequencer out of idle, so ready drops
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready |=> !s_tready) else $error("ready right after accept");
endmodule

bind linear_regression_sgd_engine lrs_checker u_chk (.*);

/* tb/tb_linear_regression_sgd_engine.sv */
// testbench of the regression engine: directed table plus random training runs
module tb_linear_regression_sgd_engine;
  import lrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]        idx;
    logic [VAL_W-1:0]  val;
    logic              kind;
    logic              last;
  } res_t;

  typedef struct {
    op_e               op;
    logic [IN_W-1:0]   in_idx;
    logic [OUT_W-1:0]  out_idx;
    logic [VAL_W-1:0]  val;
    logic [RATE_W-1:0] rate;
    logic              has_exp;
    logic [VAL_W-1:0]  exp_val;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  linear_regression_sgd_engine dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic signed [VAL_W-1:0] w_mdl [MAX_INPUTS][MAX_OUTPUTS];
  logic signed [VAL_W-1:0] b_mdl [MAX_OUTPUTS];
  logic signed [VAL_W-1:0] x_mdl [MAX_INPUTS];
  logic signed [ACC_W-1:0] acc_mdl [MAX_OUTPUTS];
  int n_in = 16, n_out = 4;
  res_t pending_q[$];
  logic [VAL_W-1:0] fixed_q[$];
  logic fixed_has_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit feat_valid [MAX_INPUTS];

  function automatic longint rnd16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic longint sat(longint v, int bits);
    longint hi = (64'sd1 <<< (bits - 1)) - 1;
    longint lo = -(64'sd1 <<< (bits - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  task automatic predict(input row_t r);
    longint a, y, e, p;
    int oi;
    oi = r.out_idx;
    case (r.op)
      OP_LOAD_W: w_mdl[r.in_idx][oi] = r.val;
      OP_LOAD_B: b_mdl[oi] = r.val;
      OP_SAMPLE: begin
        if (r.in_idx < n_in) begin
          x_mdl[r.in_idx] = r.val;
          feat_valid[r.in_idx] = 1'b1;
          for (int k = 0; k < MAX_OUTPUTS; k++) begin
            a = (r.in_idx == 0) ? longint'(b_mdl[k]) : longint'(acc_mdl[k]);
            a += rnd16(longint'(w_mdl[r.in_idx][k]) * longint'($signed(r.val)));
            acc_mdl[k] = ACC_W'(sat(a, ACC_W));
          end
          if (r.in_idx == n_in - 1)
            for (int k = 0; k < n_out; k++) begin
              pending_q.push_back('{2'(k), VAL_W'(sat(acc_mdl[k], VAL_W)), 1'b0,
                                    k == n_out - 1});
              fixed_has_q.push_back(r.has_exp && k == 0);
              fixed_q.push_back(r.exp_val);
            end
        end
      end
      OP_TARGET: begin
        if (oi < n_out) begin
          y = sat(acc_mdl[oi], VAL_W);
          e = sat(longint'($signed(r.val)) - y, VAL_W);
          pending_q.push_back('{r.out_idx, VAL_W'(e), 1'b1, 1'b1});
          fixed_has_q.push_back(r.has_exp);
          fixed_q.push_back(r.exp_val);
          b_mdl[oi] = VAL_W'(sat(longint'(b_mdl[oi]) + rnd16(e * longint'(r.rate)), VAL_W));
          for (int i = 0; i < n_in; i++) begin
            p = rnd16(e * longint'(x_mdl[i]));
            w_mdl[i][oi] = VAL_W'(sat(longint'(w_mdl[i][oi]) + rnd16(p * longint'(r.rate)),
                                      VAL_W));
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    res_t want, got;
    logic has_fix;
    logic [VAL_W-1:0] fix;
    if (s_tvalid && s_tready || m_tvalid && m_tready || cfg_valid_i && cfg_ready_o)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (m_tvalid && m_tready) begin
      got = '{m_tdata[1:0], m_tdata[25:2], m_tuser, m_tlast};
      if (pending_q.size() == 0) begin
        report("unexpected item", m_tdata, 0);
      end else begin
        want = pending_q.pop_front();
        has_fix = fixed_has_q.pop_front();
        fix = fixed_q.pop_front();
        if (got.idx !== want.idx) report("res_index", got.idx, want.idx);
        if (got.val !== want.val) report("res_value", got.val, want.val);
        if (has_fix && got.val !== fix) report("res_value table", got.val, fix);
        if (got.kind !== want.kind) report("res_kind", got.kind, want.kind);
        if (got.last !== want.last) report("last", got.last, want.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("linear_regression_sgd_engine regression: fail");
      $finish;
    end
  end

  // receiver stalls: mostly short, sometimes long, sometimes none
  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        repeat (gap) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(0, 20)) @(negedge clk_i);
    end
  end

  task automatic send(input row_t r);
    s_tdata <= {2'b0, r.rate, r.val, r.out_idx, r.in_idx};
    s_tuser <= r.op;
    s_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    predict(r);
    @(negedge clk_i);
    if ($urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3))
        @(negedge clk_i);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    // an ignored item may still be in flight
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    drain();
    cfg_index_i <= idx;
    cfg_data_i <= d;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_INPUT_COUNT) n_in = (d[4:0] < 1) ? 1 : (d[4:0] > 16) ? 16 : d[4:0];
    if (idx == REG_OUTPUT_COUNT) n_out = (d[2:0] < 1) ? 1 : (d[2:0] > 4) ? 4 : d[2:0];
  endtask

  function automatic row_t mk(op_e op, int ii, int oi, logic [VAL_W-1:0] v, int rt);
    row_t r;
    r = '{op, IN_W'(ii), OUT_W'(oi), v, RATE_W'(rt), 1'b0, '0};
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return VAL_W'($urandom);
      default: return VAL_W'(int'($urandom_range(0, 2 * 65536 * 4)) - 4 * 65536);
    endcase
  endfunction

  // a full sample followed by targets on a few outputs
  task automatic training_round();
    for (int i = 0; i < n_in; i++) begin
      send(mk(OP_SAMPLE, i, $urandom_range(0, 3), rand_val(), $urandom));
      if ($urandom_range(0, 9) == 0) send(mk(OP_LOAD_W, $urandom, $urandom, rand_val(), 0));
    end
    repeat ($urandom_range(0, 3))
      send(mk(OP_TARGET, 0, $urandom_range(0, 3), rand_val(), $urandom));
  endtask

  initial begin
    row_t tbl[$];
    row_t r;
    for (int i = 0; i < MAX_INPUTS; i++) begin
      x_mdl[i] = '0;
      feat_valid[i] = 1'b0;
      for (int k = 0; k < MAX_OUTPUTS; k++) w_mdl[i][k] = '0;
    end
    for (int k = 0; k < MAX_OUTPUTS; k++) begin
      b_mdl[k] = '0;
      acc_mdl[k] = '0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_reg(REG_INPUT_COUNT, 8'd1);
    write_reg(REG_OUTPUT_COUNT, 8'd4);
    // after reset, all predictions are zero
    r = mk(OP_SAMPLE, 0, 0, 24'h7fffff, 0); r.has_exp = 1; r.exp_val = '0; tbl.push_back(r);
    tbl.push_back(mk(OP_SAMPLE, 5, 0, 24'h123456, 0));
    tbl.push_back(mk(OP_LOAD_W, 0, 0, 24'h7fffff, 0));
    tbl.push_back(mk(OP_LOAD_W, 0, 3, 24'h800000, 0));
    tbl.push_back(mk(OP_LOAD_W, 15, 2, 24'h010000, 0));
    tbl.push_back(mk(OP_LOAD_B, 0, 1, 24'h7fffff, 0));
    tbl.push_back(mk(OP_LOAD_B, 0, 2, 24'h800000, 0));
    // output zero saturates high
    r = mk(OP_SAMPLE, 0, 0, 24'h7fffff, 0); r.has_exp = 1; r.exp_val = 24'h7fffff;
    tbl.push_back(r);
    tbl.push_back(mk(OP_SAMPLE, 0, 0, 24'h800000, 0));
    tbl.push_back(mk(OP_TARGET, 0, 0, 24'h800000, 16'hffff));
    tbl.push_back(mk(OP_TARGET, 0, 1, 24'h7fffff, 16'h0000));
    tbl.push_back(mk(OP_TARGET, 0, 2, 24'h7fffff, 16'h8000));
    tbl.push_back(mk(OP_TARGET, 0, 3, 24'h000000, 16'h0001));
    tbl.push_back(mk(OP_SAMPLE, 0, 0, 24'h010000, 0));
    tbl.push_back(mk(OP_SAMPLE, 15, 3, 24'hffffff, 16'hffff));
    foreach (tbl[i]) send(tbl[i]);

    // targets past the outputs in use are ignored
    write_reg(REG_OUTPUT_COUNT, 8'd2);
    send(mk(OP_TARGET, 0, 3, 24'h0a0000, 16'h1000));
    send(mk(OP_TARGET, 0, 1, 24'h0a0000, 16'h1000));
    write_reg(REG_OUTPUT_COUNT, 8'd0);
    send(mk(OP_SAMPLE, 0, 0, 24'h020000, 0));
    write_reg(REG_INPUT_COUNT, 8'd0);
    send(mk(OP_SAMPLE, 0, 0, 24'h030000, 0));
    write_reg(REG_INPUT_COUNT, 8'd31);
    write_reg(REG_OUTPUT_COUNT, 8'd7);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(REG_INPUT_COUNT, 8'd16); write_reg(REG_OUTPUT_COUNT, 8'd4); end
        1: begin write_reg(REG_INPUT_COUNT, 8'd3); write_reg(REG_OUTPUT_COUNT, 8'd1); end
        2: begin write_reg(REG_INPUT_COUNT, 8'd1); write_reg(REG_OUTPUT_COUNT, 8'd3); end
        3: begin write_reg(REG_INPUT_COUNT, 8'd4); write_reg(REG_OUTPUT_COUNT, 8'd4); end
        4: begin write_reg(REG_INPUT_COUNT, 8'd8); write_reg(REG_OUTPUT_COUNT, 8'd2); end
        default: begin write_reg(REG_INPUT_COUNT, 8'd16); write_reg(REG_OUTPUT_COUNT, 8'd4); end
      endcase
      repeat (4) send(mk(OP_LOAD_W, $urandom, $urandom, rand_val(), 0));
      send(mk(OP_LOAD_B, 0, $urandom, rand_val(), 0));
      for (int t = 0; t < ((n_in > 8) ? 2 : 6); t++) training_round();
      // noise: stray elements and out of range features
      repeat (3) begin
        r = mk(op_e'($urandom_range(0, 2)), $urandom, $urandom, rand_val(), $urandom);
        send(r);
      end
      if (phase == 2) drain();
    end

    drain();
    if (errors == 0)
      $display("linear_regression_sgd_engine regression: pass");
    else
      $display("linear_regression_sgd_engine regression: fail");
    $finish;
  end

endmodule
